/* rtl/ffia_pkg.sv */
// shared types and constants for the first-fit interval assign core
package ffia_pkg;

	localparam int unsigned NUM_RESOURCES_DEF = 16;
	localparam int unsigned TIME_W = 16;
	localparam int unsigned END_W  = TIME_W + 1;
	localparam int unsigned IDX_W  = 4;

	// request codes carried on s_tuser
	localparam logic OP_ASSIGN = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	// request broadcast to every cell
	typedef struct packed {
		logic              fire;
		logic              clear;
		logic [TIME_W-1:0] start_time;
		logic [END_W-1:0]  end_time;
	} ffia_req_t;

	// first-fit token handed from cell to cell
	typedef struct packed {
		logic             taken;
		logic [IDX_W-1:0] idx;
	} ffia_chain_t;

endpackage

/* rtl/ffia_cell.sv */
// one resource cell: latest end time, used flag and first-fit claim
module ffia_cell #(
	parameter int unsigned CELL_IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ffia_pkg::ffia_req_t   req,
	input  ffia_pkg::ffia_chain_t chain_in,
	output ffia_pkg::ffia_chain_t chain_out
);
	import ffia_pkg::*;

	logic [END_W-1:0] end_q;
	logic             used_q;
	logic             free;
	logic             grant;

	// free when empty or the stored end is not after the new start
	always_comb begin
		free  = !used_q || (end_q <= {1'b0, req.start_time});
		grant = free && !chain_in.taken;
		chain_out.taken = chain_in.taken || free;
		chain_out.idx   = grant ? IDX_W'(CELL_IDX) : chain_in.idx;
	end

	// used flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (req.fire) begin
			if (req.clear) begin
				used_q <= 1'b0;
			end else if (grant) begin
				used_q <= 1'b1;
			end
		end
	end

	// latest end time, only meaningful while used
	always_ff @(posedge clk) begin
		if (req.fire && !req.clear && grant && (!used_q || req.end_time > end_q)) begin
			end_q <= req.end_time;
		end
	end

endmodule

/* rtl/first_fit_interval_assign_core.sv */
// top level: request register, chain of resource cells and result register
// flow: an accepted request waits in the request register until the output
//   register is free, and its result is then registered in the output register
// throughput: one request per cycle while m_tready stays high; the cell
//   chain compares one request against all resources combinationally
// reset: arst_n clears every used flag and the pending and output valid
//   flags at once; no clearing pass is needed
module first_fit_interval_assign_core #(
	parameter int unsigned NUM_RESOURCES = ffia_pkg::NUM_RESOURCES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // start_time [15:0], task_length [31:16]
	input  logic        s_tuser,   // op [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // assigned_resource [3:0], zero [7:4]
	output logic        m_tuser    // overflow [0]
);
	import ffia_pkg::*;

	logic              pend_q;
	logic              op_s1;
	logic [TIME_W-1:0] start_s1;
	logic [END_W-1:0]  end_s1;
	logic              fire;
	logic              s_accept;
	logic              m_tvalid_q;
	logic [IDX_W-1:0]  res_idx_q;
	logic              ovf_q;
	ffia_req_t         req;
	ffia_chain_t       links [NUM_RESOURCES+1];

	// handshake control
	assign fire     = pend_q && (!m_tvalid_q || m_tready);
	assign s_tready = !pend_q || fire;
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (s_accept) begin
			pend_q <= 1'b1;
		end else if (fire) begin
			pend_q <= 1'b0;
		end
	end

	// request register with the end time formed on entry
	always_ff @(posedge clk) begin
		if (s_accept) begin
			op_s1    <= s_tuser;
			start_s1 <= s_tdata[TIME_W-1:0];
			end_s1   <= {1'b0, s_tdata[TIME_W-1:0]} + {1'b0, s_tdata[2*TIME_W-1:TIME_W]};
		end
	end

	// broadcast to the cells
	always_comb begin
		req.fire       = fire;
		req.clear      = (op_s1 == OP_CLEAR);
		req.start_time = start_s1;
		req.end_time   = end_s1;
	end

	// chain of resource cells, lowest index first
	assign links[0] = '0;

	for (genvar i = 0; i < NUM_RESOURCES; i++) begin : g_cell
		ffia_cell #(
			.CELL_IDX (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.req       (req),
			.chain_in  (links[i]),
			.chain_out (links[i+1])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (op_s1 == OP_CLEAR) begin
				res_idx_q <= '0;
				ovf_q     <= 1'b0;
			end else begin
				res_idx_q <= links[NUM_RESOURCES].idx;
				ovf_q     <= !links[NUM_RESOURCES].taken;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0000, res_idx_q};
	assign m_tuser  = ovf_q;

`ifndef ASSERT_OFF
	// a fired request always shows up as a result next cycle
	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> m_tvalid_q)
		else $error("fired request produced no result");

	// a stalled pending request stays pending
	a_pend_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q && !fire) |=> pend_q)
		else $error("pending request lost while stalled");

	// overflow results carry index zero
	a_ovf_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && ovf_q) |-> (res_idx_q == '0))
		else $error("overflow result with nonzero index");

	// a full output register blocks a new result unless drained
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tready) |-> !fire)
		else $error("result overwritten before it was taken");
`endif

endmodule
